/* rtl/xsr_pkg.sv */
// Package for the ranged xorshift32 generator.
// Holds the sequencer state type, the remainder-unit control and status structs
// and the fixed generator constants. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package xsr_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned SHIFT_A    = 13;
    localparam int unsigned SHIFT_B    = 17;
    localparam int unsigned SHIFT_C    = 5;
    localparam logic [WORD_W-1:0] SEED_RESET = 32'd2463534242;

    // Counter for the bit steps of the remainder unit. It must be able to hold WORD_W itself.
    localparam int unsigned CNT_W = $clog2(WORD_W + 1);

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_rem_ctrl;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] remainder;
    } t_rem_sts;

    function automatic logic [WORD_W-1:0] advance_word(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] t;
        t = x ^ (x << SHIFT_A);
        t = t ^ (t >> SHIFT_B);
        t = t ^ (t << SHIFT_C);
        return t;
    endfunction

endpackage

`default_nettype wire

/* rtl/xsr_rem_unit.sv */
// Radix-2 restoring remainder unit that retires one dividend bit per cycle.
// It depends on xsr_pkg for the word width and the control and status structs.
`timescale 1ns / 1ps
`default_nettype none

module xsr_rem_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire xsr_pkg::t_rem_ctrl i_ctrl,
    output xsr_pkg::t_rem_sts     o_sts
);
    import xsr_pkg::*;

    logic [WORD_W-1:0] r_rem,  n_rem;
    logic [WORD_W-1:0] r_quo,  n_quo;
    logic [WORD_W-1:0] r_div,  n_div;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic              r_busy, n_busy;
    logic              r_done, n_done;

    logic [WORD_W:0]   w_trial;
    logic [WORD_W:0]   w_diff;

    // The partial remainder stays below twice the divisor, so one extra bit is enough.
    // With a zero divisor, every subtraction removes nothing and the dividend comes out unchanged.
    assign w_trial = {r_rem, r_quo[WORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_div  = r_div;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = r_done;
        if (i_ctrl.start) begin
            n_rem  = '0;
            n_quo  = i_ctrl.dividend;
            n_div  = i_ctrl.divisor;
            n_cnt  = CNT_W'(WORD_W);
            n_busy = 1'b1;
            n_done = 1'b0;
        end else if (r_busy) begin
            n_quo = r_quo << 1;
            if (w_trial >= {1'b0, r_div}) begin
                n_rem = w_diff[WORD_W-1:0];
            end else begin
                n_rem = w_trial[WORD_W-1:0];
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_sts.busy      = r_busy;
    assign o_sts.done      = r_done;
    assign o_sts.remainder = r_rem;

endmodule

`default_nettype wire

/* rtl/xorshift32_ranged_random.sv */
// Top level of the ranged xorshift32 generator: handshakes, seed register,
// generator word, sequencer and output register. Depends on xsr_pkg and xsr_rem_unit.
`timescale 1ns / 1ps
`default_nettype none

// One request (range_low, range_high) gives one result. Once accepted, it passes through the
// bit-serial remainder unit, which starts at the accepting edge, and is then loaded into the
// output register; that load waits while an earlier result there is not taken. The block takes
// no new request in that time. The 32 steps of the remainder unit make up most of that time.
// The generator word is zero after reset. A request that finds it zero first loads it from
// the seed register, which resets to 2463534242. The result is range_low plus the advanced
// word modulo (range_high - range_low + 1), all in wrapping 32-bit arithmetic. When that span
// wraps to zero, the raw word is added. o_bounds_reversed flags range_high < range_low.
// A result that waits in the output register does not block the next request.
module xorshift32_ranged_random (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [31:0] i_seed_value,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic signed [31:0] i_range_low,
    input  wire logic signed [31:0] i_range_high,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic signed [31:0] o_random_value,
    output logic             o_bounds_reversed
);
    import xsr_pkg::*;

    t_state            r_state, n_state;
    logic [WORD_W-1:0] r_seed;
    logic [WORD_W-1:0] r_gen_word, n_gen_word;
    logic [WORD_W-1:0] r_low;
    logic              r_rev;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_value;
    logic              r_out_rev;

    logic              w_in_acc;
    logic              w_out_free;
    logic              w_load_out;
    logic [WORD_W-1:0] w_seeded;
    logic [WORD_W-1:0] w_span;
    t_rem_ctrl         w_rem_ctrl;
    t_rem_sts          w_rem_sts;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_seeded    = (r_gen_word == '0) ? r_seed : r_gen_word;
    assign n_gen_word  = advance_word(w_seeded);
    assign w_span      = WORD_W'(i_range_high) - WORD_W'(i_range_low) + WORD_W'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_BUSY;
                end
            end
            ST_BUSY: begin
                if (w_rem_sts.done && w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_ready = 1'b0;
        w_load_out = 1'b0;
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_BUSY: w_load_out = w_rem_sts.done && w_out_free;
            default: begin
                o_in_ready = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    assign w_rem_ctrl.start    = w_in_acc;
    assign w_rem_ctrl.dividend = n_gen_word;
    assign w_rem_ctrl.divisor  = w_span;

    xsr_rem_unit u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_rem_ctrl),
        .o_sts   (w_rem_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= SEED_RESET;
            r_gen_word  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_seed <= i_seed_value;
            end
            if (w_in_acc) begin
                r_gen_word <= n_gen_word;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_low <= WORD_W'(i_range_low);
            r_rev <= (i_range_high < i_range_low);
        end
        if (w_load_out) begin
            r_out_value <= r_low + w_rem_sts.remainder;
            r_out_rev   <= r_rev;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_random_value    = $signed(r_out_value);
    assign o_bounds_reversed = r_out_rev;

`ifndef SYNTHESIS
    a_idle_unit_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_rem_sts.busy)
        else $error("remainder unit busy while sequencer idle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == ST_BUSY) && w_rem_sts.busy && !w_rem_sts.done)
        else $error("accepted transaction did not start the remainder unit");

    a_word_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (r_seed != '0)) |=> (r_gen_word != '0))
        else $error("generator word zero after seeded advance");

    a_load_clears_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (r_state == ST_IDLE) && o_out_valid)
        else $error("result load did not return sequencer to idle");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the ranged xorshift32 generator, xorshift32_ranged_random.
// Predicts each draw from its own copy of the generator word and seed register.
// Depends on rtl/xsr_pkg.sv and the block's RTL.
`timescale 1ns / 1ps

module tb;

    localparam logic [31:0] INT_MIN = 32'h8000_0000;
    localparam logic [31:0] INT_MAX = 32'h7FFF_FFFF;

    typedef struct packed {
        logic signed [31:0] value;
        logic               reversed;
    } t_draw;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [31:0]        i_seed_value = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [31:0] i_range_low = '0;
    logic signed [31:0] i_range_high = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [31:0] o_random_value;
    logic               o_bounds_reversed;

    // Model of the block's state.
    logic [31:0] seed_reg = xsr_pkg::SEED_RESET;
    logic [31:0] gen_word = '0;

    t_draw       pending_draws[$];
    int unsigned error_count = 0;
    int unsigned draws_sent = 0;
    int unsigned draws_checked = 0;
    int unsigned reversed_sent = 0;
    int unsigned full_range_sent = 0;
    int unsigned seed_writes = 0;
    bit          steady_mode = 1'b0;
    int unsigned ready_hold = 0;

    xorshift32_ranged_random u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_seed_value      (i_seed_value),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_range_low       (i_range_low),
        .i_range_high      (i_range_high),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_random_value    (o_random_value),
        .o_bounds_reversed (o_bounds_reversed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Half the time no gap, often a short one, now and then a long one.
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(8, 60);
    endfunction

    // Advances the generator and works out the draw for one request.
    function automatic t_draw predict_draw(logic [31:0] lo, logic [31:0] hi);
        logic [31:0] span;
        t_draw       d;
        if (gen_word == 32'd0) gen_word = seed_reg;
        gen_word ^= gen_word << xsr_pkg::SHIFT_A;
        gen_word ^= gen_word >> xsr_pkg::SHIFT_B;
        gen_word ^= gen_word << xsr_pkg::SHIFT_C;
        span = hi - lo + 32'd1;
        d.value = (span == 32'd0) ? lo + gen_word : lo + (gen_word % span);
        d.reversed = $signed(hi) < $signed(lo);
        return d;
    endfunction

    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    // Receiver side: random back-pressure unless the steady stretch is on.
    always @(posedge i_clk) begin
        if (steady_mode) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            i_out_ready <= ~i_out_ready;
            ready_hold <= i_out_ready ? idle_len() : $urandom_range(0, 6);
        end
    end

    always @(posedge i_clk) begin
        t_draw want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_draws.size() == 0) begin
                report_mismatch($sformatf("result %h with no request pending", o_random_value));
            end else begin
                want = pending_draws.pop_front();
                draws_checked++;
                if (o_random_value !== want.value)
                    report_mismatch($sformatf("random_value %h, expected %h",
                        o_random_value, want.value));
                if (o_bounds_reversed !== want.reversed)
                    report_mismatch($sformatf("bounds_reversed %b, expected %b",
                        o_bounds_reversed, want.reversed));
            end
        end
    end

    task automatic send_draw(logic [31:0] lo, logic [31:0] hi);
        int unsigned gap;
        gap = steady_mode ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_range_low  <= lo;
        i_range_high <= hi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_draws.push_back(predict_draw(lo, hi));
        draws_sent++;
        if ($signed(hi) < $signed(lo)) reversed_sent++;
        if (hi - lo + 32'd1 == 32'd0) full_range_sent++;
    endtask

    // Holds off the sender until every outstanding transaction has been answered.
    task automatic wait_all_drawn();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_seed(logic [31:0] value);
        i_cfg_valid  <= 1'b1;
        i_seed_value <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        seed_reg = value;
        seed_writes++;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_corner();
        case ($urandom_range(0, 6))
            0: return INT_MIN;
            1: return INT_MIN + 32'd1;
            2: return 32'hFFFF_FFFF;
            3: return 32'd0;
            4: return 32'd1;
            5: return INT_MAX - 32'd1;
            default: return INT_MAX;
        endcase
    endfunction

    // A zero seed leaves a zero word at zero, so every draw returns range_low.
    task automatic test_zero_seed();
        write_seed(32'd0);
        send_draw(32'd0, 32'd100);
        send_draw(-32'sd5, 32'sd5);
        send_draw(INT_MIN, INT_MAX);
        wait_all_drawn();
        write_seed(32'hFFFF_FFFF);
    endtask

    task automatic test_full_range();
        send_draw(INT_MIN, INT_MAX);
        send_draw(INT_MIN, INT_MAX);
    endtask

    task automatic test_reversed_bounds();
        send_draw(32'sd10, -32'sd10);
        send_draw(INT_MAX, INT_MIN);
        send_draw(32'd5, 32'd4);
        send_draw(32'd0, 32'hFFFF_FFFF);
        send_draw(INT_MIN, INT_MAX - 32'd1);
    endtask

    task automatic test_corner_bounds();
        send_draw(32'd7, 32'd7);
        send_draw(INT_MIN, INT_MIN);
        send_draw(INT_MAX, INT_MAX);
        send_draw(32'd0, INT_MAX);
        send_draw(INT_MIN, 32'd0);
        send_draw(INT_MIN, 32'hFFFF_FFFF);
        send_draw(32'd0, 32'd1);
        send_draw(32'hFFFF_FFFF, 32'd0);
    endtask

    task automatic random_draws(int unsigned count);
        logic [31:0] lo;
        logic [31:0] hi;
        int unsigned k;
        repeat (count) begin
            lo = $urandom;
            case ($urandom_range(0, 9))
                0, 1, 2: hi = $urandom;
                3, 4: hi = lo + $urandom_range(0, 20);
                5: begin
                    k = $urandom_range(0, 31);
                    hi = lo + (32'd1 << k) - 32'd1;
                end
                6: hi = lo - $urandom_range(1, 1000);
                7: begin
                    lo = INT_MIN + $urandom_range(0, 3);
                    hi = INT_MAX - $urandom_range(0, 3);
                end
                8: begin
                    lo = pick_corner();
                    hi = pick_corner();
                end
                default: begin
                    lo = -$urandom_range(0, 1000);
                    hi = $urandom_range(0, 1000);
                end
            endcase
            send_draw(lo, hi);
        end
    endtask

    task automatic test_random_traffic();
        wait_all_drawn();
        write_seed(32'd1);
        random_draws(400);
        wait_all_drawn();
        random_draws(300);
        wait_all_drawn();
        write_seed($urandom);
        steady_mode = 1'b1;
        random_draws(250);
        wait_all_drawn();
        steady_mode = 1'b0;
        write_seed(32'h8000_0000);
        random_draws(580);
    endtask

    initial begin
        int unsigned waited;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_seed();
        test_full_range();
        test_reversed_bounds();
        test_corner_bounds();
        test_random_traffic();

        i_in_valid <= 1'b0;
        waited = 0;
        while (pending_draws.size() != 0 && waited < 20000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (50) @(posedge i_clk);
        if (pending_draws.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_draws.size()));

        $display("Sent %0d requests (%0d reversed, %0d full range) over %0d seed writes;",
            draws_sent, reversed_sent, full_range_sent, seed_writes);
        $display("checked %0d results, %0d mismatches.", draws_checked, error_count);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("Timed out with %0d results outstanding.", pending_draws.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* filelist.f */
rtl/xsr_pkg.sv
rtl/xsr_rem_unit.sv
rtl/xorshift32_ranged_random.sv
tb/tb.sv
